// ===== src/lzwd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the LZ window decompressor.
// Used by the parser, the command queue, the copier and the top level.
package lzwd_pkg;

    localparam int WINDOW_DEPTH = 4096;
    localparam int WIN_AW       = $clog2(WINDOW_DEPTH);
    localparam int OFFSET_W     = 12;
    localparam int LEN_W        = 5;
    localparam int CNT_W        = 32;
    localparam int MIN_MATCH    = 3;
    localparam int FLAG_TOKENS  = 8;
    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_AW      = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW      = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] LEN_MASK  = 8'h0f;
    localparam logic [7:0] OFFS_MASK = 8'hf0;

    typedef enum logic [1:0] {
        PH_FLAG   = 2'd0,
        PH_TOKEN  = 2'd1,
        PH_MATCH2 = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        CP_IDLE = 2'd0,
        CP_READ = 2'd1,
        CP_EMIT = 2'd2
    } copy_state_t;

    // One command per input word that produces output.
    typedef struct packed {
        logic                is_match;
        logic [OFFSET_W-1:0] arg;      // literal byte in the low bits, or the offset
        logic [LEN_W-1:0]    count;    // bytes to produce, 1..18
        logic                done;     // last byte of this command ends the stream
    } cmd_t;

    typedef struct packed {
        logic valid;
        logic ready;
    } qctl_t;

endpackage

// ===== src/lzwd_parser.sv =====
`timescale 1ns / 1ps
// Front end: takes compressed words, tracks flag bits and the byte budget,
// and turns each literal or completed match into a command. Uses lzwd_pkg.
module lzwd_parser (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [31:0]                cfg_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [7:0]                 in_byte,
    input  logic                       in_start,
    output lzwd_pkg::qctl_t            push,
    input  logic                       push_ready,
    output lzwd_pkg::cmd_t             push_cmd
);

    logic [lzwd_pkg::CNT_W-1:0] total_reg;
    logic [lzwd_pkg::CNT_W-1:0] rem_reg, rem_next, rem_eff;
    lzwd_pkg::phase_t           phase_reg, phase_next, phase_eff;
    logic [7:0]                 flags_reg, flags_next, flags_eff;
    logic [3:0]                 left_reg, left_next, left_eff, left_dec;
    logic [7:0]                 first_reg, first_next;
    logic [lzwd_pkg::LEN_W-1:0] match_len, match_cnt;
    logic                       accept;

    assign cfg_ready = 1'b1;
    assign in_ready  = push_ready;
    assign accept    = in_valid && push_ready;

    always_comb begin
        rem_eff   = in_start ? total_reg : rem_reg;
        phase_eff = in_start ? lzwd_pkg::PH_FLAG : phase_reg;
        flags_eff = in_start ? 8'd0 : flags_reg;
        left_eff  = in_start ? 4'd0 : left_reg;
        left_dec  = left_eff - 4'd1;

        match_len = {1'b0, first_reg[3:0] & lzwd_pkg::LEN_MASK[3:0]}
                    + lzwd_pkg::LEN_W'(lzwd_pkg::MIN_MATCH);
        if (lzwd_pkg::CNT_W'(match_len) > rem_eff)
            match_cnt = rem_eff[lzwd_pkg::LEN_W-1:0];
        else
            match_cnt = match_len;

        rem_next   = rem_eff;
        phase_next = phase_eff;
        flags_next = flags_eff;
        left_next  = left_eff;
        first_next = first_reg;
        push.valid = 1'b0;
        push.ready = push_ready;
        push_cmd   = '0;

        if (rem_eff != '0) begin
            unique case (phase_eff)
                lzwd_pkg::PH_TOKEN: begin
                    if (!flags_eff[7]) begin
                        push.valid        = 1'b1;
                        push_cmd.is_match = 1'b0;
                        push_cmd.arg      = {4'd0, in_byte};
                        push_cmd.count    = lzwd_pkg::LEN_W'(1);
                        push_cmd.done     = (rem_eff == lzwd_pkg::CNT_W'(1));
                        rem_next          = rem_eff - lzwd_pkg::CNT_W'(1);
                        flags_next        = {flags_eff[6:0], 1'b0};
                        left_next         = left_dec;
                        phase_next        = (left_dec == 4'd0) ? lzwd_pkg::PH_FLAG
                                                               : lzwd_pkg::PH_TOKEN;
                    end else begin
                        first_next = in_byte;
                        phase_next = lzwd_pkg::PH_MATCH2;
                    end
                end
                lzwd_pkg::PH_MATCH2: begin
                    push.valid        = 1'b1;
                    push_cmd.is_match = 1'b1;
                    push_cmd.arg      = {first_reg[7:4] & lzwd_pkg::OFFS_MASK[7:4], in_byte};
                    push_cmd.count    = match_cnt;
                    rem_next          = rem_eff - lzwd_pkg::CNT_W'(match_cnt);
                    push_cmd.done     = (rem_next == '0);
                    flags_next        = {flags_eff[6:0], 1'b0};
                    left_next         = left_dec;
                    phase_next        = (left_dec == 4'd0) ? lzwd_pkg::PH_FLAG
                                                           : lzwd_pkg::PH_TOKEN;
                end
                default: begin
                    // A flag word; the unused phase code is treated the same way.
                    flags_next = in_byte;
                    left_next  = 4'(lzwd_pkg::FLAG_TOKENS);
                    phase_next = lzwd_pkg::PH_TOKEN;
                end
            endcase
        end
        if (!accept)
            push.valid = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= '0;
            rem_reg   <= '0;
            phase_reg <= lzwd_pkg::PH_FLAG;
            flags_reg <= '0;
            left_reg  <= '0;
            first_reg <= '0;
        end else begin
            if (cfg_valid)
                total_reg <= cfg_data;
            if (accept) begin
                rem_reg   <= rem_next;
                phase_reg <= phase_next;
                flags_reg <= flags_next;
                left_reg  <= left_next;
                first_reg <= first_next;
            end
        end
    end

endmodule

// ===== src/lzwd_cmd_fifo.sv =====
`timescale 1ns / 1ps
// Short command queue between the parser and the copier.
// Uses lzwd_pkg for the command type and depth.
module lzwd_cmd_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            wr_en,
    input  lzwd_pkg::cmd_t  wr_cmd,
    output logic            not_full,
    input  logic            rd_en,
    output lzwd_pkg::cmd_t  rd_cmd,
    output logic            not_empty
);

    lzwd_pkg::cmd_t                 slots [lzwd_pkg::FIFO_DEPTH];
    logic [lzwd_pkg::FIFO_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [lzwd_pkg::FIFO_CW-1:0]   fill_reg;
    logic                           do_wr, do_rd;

    assign not_full  = (fill_reg != lzwd_pkg::FIFO_CW'(lzwd_pkg::FIFO_DEPTH));
    assign not_empty = (fill_reg != '0);
    assign do_wr     = wr_en && not_full;
    assign do_rd     = rd_en && not_empty;
    assign rd_cmd    = slots[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_wr)
            slots[wr_ptr_reg] <= wr_cmd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (do_wr)
                wr_ptr_reg <= wr_ptr_reg + lzwd_pkg::FIFO_AW'(1);
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + lzwd_pkg::FIFO_AW'(1);
            if (do_wr && !do_rd)
                fill_reg <= fill_reg + lzwd_pkg::FIFO_CW'(1);
            else if (do_rd && !do_wr)
                fill_reg <= fill_reg - lzwd_pkg::FIFO_CW'(1);
        end
    end

endmodule

// ===== src/lzwd_copier.sv =====
`timescale 1ns / 1ps
// Back end: carries out literal and match commands against the history
// window and drives the output register. Uses lzwd_pkg.
module lzwd_copier (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cmd_avail,
    input  lzwd_pkg::cmd_t  cmd,
    output logic            cmd_pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      out_byte,
    output logic            out_last,
    output logic            out_done
);

    logic [7:0]                   window [lzwd_pkg::WINDOW_DEPTH];
    lzwd_pkg::copy_state_t        state_reg, state_next;
    lzwd_pkg::cmd_t               cur_reg, cur_next;
    logic [lzwd_pkg::WIN_AW-1:0]  wp_reg, rd_addr;
    logic                         wrapped_reg;
    logic [7:0]                   rd_data_reg, emit_byte;
    logic                         rd_valid_reg;
    logic                         out_valid_reg;
    logic [7:0]                   out_byte_reg;
    logic                         out_last_reg, out_done_reg;
    logic                         out_free, emit;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;
    assign out_done  = out_done_reg;

    assign rd_addr = wp_reg - lzwd_pkg::WIN_AW'(cur_reg.arg);

    // Entries not yet written since reset read as zero: before the first
    // wrap only addresses below the write position hold data.
    always_comb begin
        if (!cur_reg.is_match)
            emit_byte = cur_reg.arg[7:0];
        else if (rd_valid_reg)
            emit_byte = rd_data_reg;
        else
            emit_byte = 8'd0;
    end

    always_comb begin
        state_next = state_reg;
        cur_next   = cur_reg;
        cmd_pop    = 1'b0;
        emit       = 1'b0;
        unique case (state_reg)
            lzwd_pkg::CP_IDLE: begin
                if (cmd_avail) begin
                    cmd_pop    = 1'b1;
                    cur_next   = cmd;
                    state_next = cmd.is_match ? lzwd_pkg::CP_READ : lzwd_pkg::CP_EMIT;
                end
            end
            lzwd_pkg::CP_READ: begin
                state_next = lzwd_pkg::CP_EMIT;
            end
            lzwd_pkg::CP_EMIT: begin
                if (out_free) begin
                    emit           = 1'b1;
                    cur_next.count = cur_reg.count - lzwd_pkg::LEN_W'(1);
                    if (cur_reg.count == lzwd_pkg::LEN_W'(1))
                        state_next = lzwd_pkg::CP_IDLE;
                    else
                        state_next = lzwd_pkg::CP_READ;
                end
            end
            default: state_next = lzwd_pkg::CP_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (state_reg == lzwd_pkg::CP_READ)
            rd_data_reg <= window[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (emit)
            window[wp_reg] <= emit_byte;
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        if (state_reg == lzwd_pkg::CP_READ)
            rd_valid_reg <= wrapped_reg || (rd_addr < wp_reg);
        if (emit) begin
            out_byte_reg <= emit_byte;
            out_last_reg <= (cur_reg.count == lzwd_pkg::LEN_W'(1));
            out_done_reg <= cur_reg.done && (cur_reg.count == lzwd_pkg::LEN_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= lzwd_pkg::CP_IDLE;
            wp_reg        <= '0;
            wrapped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (emit) begin
                wp_reg <= wp_reg + lzwd_pkg::WIN_AW'(1);
                if (wp_reg == '1)
                    wrapped_reg <= 1'b1;
            end
            if (emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

endmodule

// ===== src/lz_window_decompressor_unit.sv =====
`timescale 1ns / 1ps
// LZSS decompressor with a 4096-byte history window, 12-bit offset, 4-bit length.
// Top level: parser, command queue and copier. Uses lzwd_pkg.
//
// Usage:
//   cfg_valid/cfg_data write the total output length; it is sampled by the
//   next input word that carries the stream start flag (s_tuser).
//   s_tdata carries compressed words: flag words, literals and match words.
//   m_tdata carries decompressed bytes; m_tlast marks the last byte produced
//   by one input word and m_tuser marks the final byte of the stream.
// Flow:
//   The parser takes one word per cycle while the four-entry command queue
//   has room. The copier takes a command in its idle state, emits a literal
//   byte from its emit state, and for each copied byte of a match passes a
//   read state (the window read) before the emit state (the write-back);
//   it takes a new command only back in idle. A byte goes through the queue,
//   the copier's states and the output register before m_tvalid rises.
// Reset: aresetn, synchronous, active low, clears parser, queue and copier.
//   The window needs no clearing pass: entries not yet written read as zero.
// Stall: when m_tready is low the copier holds, the queue fills, and then
//   s_tready drops; no word is lost.
module lz_window_decompressor_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,     // total_output_length
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,      // [7:0] in_byte
    input  logic        s_tuser,      // [0] stream_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,      // [7:0] out_byte
    output logic        m_tlast,      // run_last
    output logic        m_tuser       // [0] stream_done
);

    lzwd_pkg::qctl_t push;
    lzwd_pkg::cmd_t  push_cmd, pop_cmd;
    logic            q_not_full, q_not_empty, q_pop;

    lzwd_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_byte    (s_tdata),
        .in_start   (s_tuser),
        .push       (push),
        .push_ready (q_not_full),
        .push_cmd   (push_cmd)
    );

    lzwd_cmd_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (push.valid && push.ready),
        .wr_cmd    (push_cmd),
        .not_full  (q_not_full),
        .rd_en     (q_pop),
        .rd_cmd    (pop_cmd),
        .not_empty (q_not_empty)
    );

    lzwd_copier u_copier (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_avail (q_not_empty),
        .cmd       (pop_cmd),
        .cmd_pop   (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_byte  (m_tdata),
        .out_last  (m_tlast),
        .out_done  (m_tuser)
    );

endmodule
